// File: sv/thb_pkg.sv
// Shared constants, types and helper functions for the thermal head strobe batcher.
// No dependencies; every other file imports this package.
package thb_pkg;

    // Line and head geometry
    localparam int LINE_BYTES = 48;
    localparam int HEAD_BYTES = 48;
    localparam int SEG_BYTES  = 8;
    localparam int SEGMENTS   = HEAD_BYTES / SEG_BYTES;
    localparam int BANKS      = 2;
    localparam int QDEPTH     = 2;

    localparam int POS_W   = $clog2(LINE_BYTES);
    localparam int IDX_W   = $clog2(HEAD_BYTES);
    localparam int COL_W   = $clog2(SEG_BYTES);
    localparam int SEG_W   = 3;
    localparam int BANK_W  = $clog2(BANKS);
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 9;
    localparam int DENS_W     = 7;
    localparam int TIME_W     = 16;
    localparam int COILS_W    = 4;
    localparam int PHASE_W    = 3;
    localparam int STEP_W     = 2;
    localparam int DOTS_W     = SEG_BYTES * BYTE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [SEG_W-1:0]  SEG_LAST  = SEG_W'(SEGMENTS - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(3);

    // base*density/100: reciprocal multiply, exact for products below 2**23
    localparam int PROD_W   = TIME_W + DENS_W;
    localparam int RECIP_W  = 24;
    localparam int DIV_SH   = 30;
    localparam logic [RECIP_W-1:0] DIV100_RECIP = 24'd10737419;
    localparam int QUO_W    = PROD_W + RECIP_W - DIV_SH;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Result kinds
    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_MOTOR   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DOT_LIMIT    = 3'd0,
        REG_DARKNESS     = 3'd1,
        REG_BASE_HEAT_US = 3'd2,
        REG_COOL_US      = 3'd3,
        REG_STEP_WAIT_US = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_EVAL,
        FR_PLACE,
        FR_LINE
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SEG,
        BK_STEP,
        BK_OFF
    } back_state_t;

    // Work handed from front to back: one batch, maybe closing a line
    typedef struct packed {
        logic [BANK_W-1:0]  bank;
        logic [COUNT_W-1:0] count;
        logic               line_end;
        logic               job_end;
    } cmd_t;

    typedef struct packed {
        logic               en;
        logic [BANK_W-1:0]  bank;
        logic [IDX_W-1:0]   idx;
        logic [BYTE_W-1:0]  data;
    } store_wr_t;

    typedef struct packed {
        logic              en;
        logic [BANK_W-1:0] bank;
    } bank_rel_t;

    function automatic logic [3:0] popcount8(input logic [BYTE_W-1:0] b);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            n = n + 4'(b[i]);
        end
        return n;
    endfunction

    // Half-step coil table, AP AM BP BM from bit 3 down
    function automatic logic [COILS_W-1:0] phase_coils(input logic [PHASE_W-1:0] p);
        logic [COILS_W-1:0] c;
        unique case (p)
            3'd0:    c = 4'd8;
            3'd1:    c = 4'd10;
            3'd2:    c = 4'd2;
            3'd3:    c = 4'd6;
            3'd4:    c = 4'd4;
            3'd5:    c = 4'd5;
            3'd6:    c = 4'd1;
            3'd7:    c = 4'd9;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: sv/thb_if.sv
// Valid/ready channel interfaces: image input, result output, register writes.
// Depends on thb_pkg for field widths.
interface thb_in_if import thb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] dot_byte;
    logic              job_last;

    modport source (output valid, output dot_byte, output job_last, input ready);
    modport sink   (input valid, input dot_byte, input job_last, output ready);
endinterface

interface thb_out_if import thb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [SEG_W-1:0]   segment;
    logic [DOTS_W-1:0]  dots;
    logic [COUNT_W-1:0] batch_dots;
    logic [TIME_W-1:0]  heat_us;
    logic [TIME_W-1:0]  pause_us;
    logic [COILS_W-1:0] coils;
    logic [TIME_W-1:0]  wait_us;
    logic               batch_last;
    logic               line_last;
    logic               job_done;

    modport source (output valid, output kind, output segment, output dots,
                    output batch_dots, output heat_us, output pause_us, output coils,
                    output wait_us, output batch_last, output line_last,
                    output job_done, input ready);
    modport sink   (input valid, input kind, input segment, input dots,
                    input batch_dots, input heat_us, input pause_us, input coils,
                    input wait_us, input batch_last, input line_last,
                    input job_done, output ready);
endinterface

interface thb_cfg_if import thb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/thb_store.sv
// Two-bank batch store: byte writes from the front, registered segment reads and
// bank release from the back. Depends on thb_pkg.
module thb_store import thb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  store_wr_t          wr,
    input  bank_rel_t          rel,
    input  logic [BANK_W-1:0]  rd_bank,
    input  logic [SEG_W-1:0]   rd_seg,
    output logic [DOTS_W-1:0]  rd_dots
);

    logic [BYTE_W-1:0]     data_reg [BANKS][SEGMENTS][SEG_BYTES];
    logic [HEAD_BYTES-1:0] vld_reg  [BANKS];
    logic [HEAD_BYTES-1:0] vld_next [BANKS];
    logic [DOTS_W-1:0]     rd_dots_reg;

    logic [SEG_W-1:0] wr_row;
    logic [COL_W-1:0] wr_col;

    assign wr_row = wr.idx[IDX_W-1:COL_W];
    assign wr_col = wr.idx[COL_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            data_reg[wr.bank][wr_row][wr_col] <= wr.data;
        end
    end

    // release clears a whole bank at once
    always_comb
    begin
        for (int b = 0; b < BANKS; b++)
        begin
            vld_next[b] = vld_reg[b];
            if (rel.en && (rel.bank == BANK_W'(b)))
            begin
                vld_next[b] = '0;
            end
            if (wr.en && (wr.bank == BANK_W'(b)))
            begin
                vld_next[b][wr.idx] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < BANKS; b++)
            begin
                vld_reg[b] <= '0;
            end
        end
        else
        begin
            for (int b = 0; b < BANKS; b++)
            begin
                vld_reg[b] <= vld_next[b];
            end
        end
    end

    // one row per cycle, data out the cycle after the address;
    // first byte of the segment lands in the top byte
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < SEG_BYTES; c++)
        begin
            rd_dots_reg[(SEG_BYTES-1-c)*BYTE_W +: BYTE_W] <=
                vld_reg[rd_bank][{rd_seg, COL_W'(c)}] ? data_reg[rd_bank][rd_seg][c] : '0;
        end
    end

    assign rd_dots = rd_dots_reg;

endmodule

// File: sv/thb_queue.sv
// Short command queue between the front and the back.
// Depends on thb_pkg for cmd_t.
module thb_queue import thb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    cmd_t              ent_reg [QDEPTH];
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QCNT_W-1:0] cnt_reg,    cnt_next;

    assign full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = ent_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: sv/thb_front.sv
// Front end: takes image bytes, counts dots, fills the current store bank and
// hands closed batches to the queue. Depends on thb_pkg and thb_if.
module thb_front import thb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    thb_in_if.sink             din,
    input  logic [COUNT_W-1:0] dot_limit,
    input  bank_rel_t          rel,
    input  logic               q_full,
    output logic               q_push,
    output cmd_t               q_cmd,
    output store_wr_t          wr
);

    front_state_t       state_reg, state_next;
    logic [BYTE_W-1:0]  byte_reg;
    logic               job_reg;
    logic [COUNT_W-1:0] cnt_reg,  cnt_next;
    logic [POS_W-1:0]   pos_reg,  pos_next;
    logic [BANK_W-1:0]  bank_reg, bank_next;
    logic [BANKS-1:0]   busy_reg, busy_next;

    logic [3:0]         pc;
    logic [COUNT_W:0]   sum;
    logic               over;
    logic               line_end;
    logic               cur_free;
    logic               do_write;
    logic               do_push;
    logic               in_head;

    assign pc       = popcount8(byte_reg);
    assign sum      = {1'b0, cnt_reg} + (COUNT_W+1)'(pc);
    assign over     = (sum > {1'b0, dot_limit});
    assign line_end = (pos_reg == POS_W'(LINE_BYTES-1)) || job_reg;
    assign cur_free = !busy_reg[bank_reg];
    assign in_head  = (32'(pos_reg) < 32'(HEAD_BYTES));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE:
            begin
                if (din.valid)
                begin
                    state_next = FR_EVAL;
                end
            end
            FR_EVAL:
            begin
                if (cur_free)
                begin
                    if (over)
                    begin
                        if (!q_full)
                        begin
                            state_next = FR_PLACE;
                        end
                    end
                    else
                    begin
                        state_next = line_end ? FR_LINE : FR_IDLE;
                    end
                end
            end
            FR_PLACE:
            begin
                if (cur_free)
                begin
                    state_next = line_end ? FR_LINE : FR_IDLE;
                end
            end
            FR_LINE:
            begin
                if (!q_full)
                begin
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        do_write = 1'b0;
        do_push  = 1'b0;
        unique case (state_reg)
            FR_EVAL:
            begin
                do_write = cur_free && !over;
                do_push  = cur_free && over && !q_full;
            end
            FR_PLACE: do_write = cur_free;
            FR_LINE:  do_push  = !q_full;
            default:
            begin
                do_write = 1'b0;
                do_push  = 1'b0;
            end
        endcase
        din.ready        = (state_reg == FR_IDLE);
        q_push           = do_push;
        q_cmd.bank       = bank_reg;
        q_cmd.count      = cnt_reg;
        q_cmd.line_end   = (state_reg == FR_LINE);
        q_cmd.job_end    = (state_reg == FR_LINE) && job_reg;
        wr.en            = do_write && in_head;
        wr.bank          = bank_reg;
        wr.idx           = IDX_W'(pos_reg);
        wr.data          = byte_reg;
    end

    // batch bookkeeping
    always_comb
    begin
        cnt_next  = cnt_reg;
        pos_next  = pos_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        if (rel.en)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (do_push)
        begin
            busy_next[bank_reg] = 1'b1;
            bank_next           = ~bank_reg;
            cnt_next            = '0;
        end
        if (do_write)
        begin
            cnt_next = sum[COUNT_W-1:0];
            pos_next = line_end ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (din.valid && din.ready)
        begin
            byte_reg <= din.dot_byte;
            job_reg  <= din.job_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            bank_reg  <= '0;
            busy_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

// File: sv/thb_back.sv
// Back end with the heat-time pipeline: plays queued batches as six segments, then
// motor half-steps at line end, coils off at job end; depends on thb_pkg, thb_if.
module thb_back import thb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    thb_out_if.source          dout,
    input  logic [DENS_W-1:0]  darkness,
    input  logic [TIME_W-1:0]  base_heat_us,
    input  logic [TIME_W-1:0]  cool_us,
    input  logic [TIME_W-1:0]  step_wait_us,
    input  logic               q_empty,
    input  cmd_t               q_head,
    output logic               q_pop,
    output bank_rel_t          rel,
    output logic [BANK_W-1:0]  rd_bank,
    output logic [SEG_W-1:0]   rd_seg,
    input  logic [DOTS_W-1:0]  rd_dots
);

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg;
    logic [SEG_W-1:0]   seg_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic               out_valid_reg;

    logic [PROD_W-1:0]  prod_reg;
    logic [TIME_W-1:0]  heat_reg;
    logic [PROD_W+RECIP_W-1:0] recip_prod;
    logic [QUO_W-1:0]   quo;

    logic               kind_reg;
    logic [SEG_W-1:0]   segment_reg;
    logic [DOTS_W-1:0]  dots_reg;
    logic [COUNT_W-1:0] batch_dots_reg;
    logic [TIME_W-1:0]  heat_us_reg;
    logic [TIME_W-1:0]  pause_us_reg;
    logic [COILS_W-1:0] coils_reg;
    logic [TIME_W-1:0]  wait_us_reg;
    logic               batch_last_reg;
    logic               line_last_reg;
    logic               job_done_reg;

    logic adv;
    logic load_seg;
    logic load_step;
    logic load_off;
    logic hot;

    // heat time tracks the registers through prod_reg and then heat_reg
    assign recip_prod = PROD_W'(prod_reg) * DIV100_RECIP;
    assign quo        = recip_prod[PROD_W+RECIP_W-1:DIV_SH];

    always_ff @(posedge clk)
    begin
        prod_reg <= base_heat_us * PROD_W'(darkness);
        heat_reg <= (quo > QUO_W'(TIME_MAX)) ? TIME_MAX : quo[TIME_W-1:0];
    end

    assign adv = !out_valid_reg || dout.ready;
    assign hot = (cmd_reg.count != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = BK_SEG;
                end
            end
            BK_SEG:
            begin
                if (adv && (seg_reg == SEG_LAST))
                begin
                    state_next = cmd_reg.line_end ? BK_STEP : BK_IDLE;
                end
            end
            BK_STEP:
            begin
                if (adv && (step_reg == STEP_LAST))
                begin
                    state_next = cmd_reg.job_end ? BK_OFF : BK_IDLE;
                end
            end
            BK_OFF:
            begin
                if (adv)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop     = 1'b0;
        load_seg  = 1'b0;
        load_step = 1'b0;
        load_off  = 1'b0;
        unique case (state_reg)
            BK_IDLE: q_pop     = !q_empty;
            BK_SEG:  load_seg  = adv;
            BK_STEP: load_step = adv;
            BK_OFF:  load_off  = adv;
            default: q_pop     = 1'b0;
        endcase
        rel.en  = load_seg && (seg_reg == SEG_LAST);
        rel.bank = cmd_reg.bank;
        // store read is registered: address the row needed next cycle
        rd_bank = q_pop ? q_head.bank : cmd_reg.bank;
        rd_seg  = q_pop ? '0
                : (load_seg && (seg_reg != SEG_LAST)) ? seg_reg + 1'b1 : seg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_head;
        end
        if (load_seg)
        begin
            kind_reg       <= KIND_SEGMENT;
            segment_reg    <= seg_reg;
            dots_reg       <= rd_dots;
            batch_dots_reg <= cmd_reg.count;
            heat_us_reg    <= hot ? heat_reg : '0;
            pause_us_reg   <= hot ? cool_us  : '0;
            coils_reg      <= '0;
            wait_us_reg    <= '0;
            batch_last_reg <= (seg_reg == SEG_LAST);
            line_last_reg  <= 1'b0;
            job_done_reg   <= 1'b0;
        end
        else if (load_step || load_off)
        begin
            kind_reg       <= KIND_MOTOR;
            segment_reg    <= '0;
            dots_reg       <= '0;
            batch_dots_reg <= '0;
            heat_us_reg    <= '0;
            pause_us_reg   <= '0;
            coils_reg      <= load_step ? phase_coils(phase_reg) : '0;
            wait_us_reg    <= (load_step && (step_reg != STEP_LAST)) ? step_wait_us : '0;
            batch_last_reg <= 1'b0;
            line_last_reg  <= load_step && (step_reg == STEP_LAST);
            job_done_reg   <= load_off;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            seg_reg       <= '0;
            step_reg      <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                seg_reg  <= '0;
                step_reg <= '0;
            end
            else if (load_seg)
            begin
                seg_reg <= (seg_reg == SEG_LAST) ? '0 : seg_reg + 1'b1;
            end
            if (load_step)
            begin
                step_reg  <= step_reg + 1'b1;
                phase_reg <= phase_reg - 1'b1;
            end
            if (load_seg || load_step || load_off)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        dout.valid      = out_valid_reg;
        dout.kind       = kind_reg;
        dout.segment    = segment_reg;
        dout.dots       = dots_reg;
        dout.batch_dots = batch_dots_reg;
        dout.heat_us    = heat_us_reg;
        dout.pause_us   = pause_us_reg;
        dout.coils      = coils_reg;
        dout.wait_us    = wait_us_reg;
        dout.batch_last = batch_last_reg;
        dout.line_last  = line_last_reg;
        dout.job_done   = job_done_reg;
    end

endmodule

// File: sv/thermal_head_batched_strobe_core.sv
// Top level of the thermal head strobe batcher: register file plus front, queue,
// store and back. Depends on thb_pkg, thb_if, thb_store, thb_queue, thb_front, thb_back.
//
//   channel  dir  word                                   accepted when
//   din      in   dot_byte, job_last                     din.valid && din.ready
//   dout     out  kind..job_done (one result word)       dout.valid && dout.ready
//   cfg      in   index, data (register write)           cfg.valid && cfg.ready
//
// The front takes a byte in FR_IDLE and checks it in FR_EVAL; closing a batch adds
// FR_PLACE, closing a line adds FR_LINE. The back pops the queue, plays six segment
// words (store row read ahead), then at line end four motor half-steps and at job
// end the coils-off word.
// A two-entry queue and a second store bank let the front keep filling while the
// back drains; reset clears the store valid bits, and a stalled output backs up.
module thermal_head_batched_strobe_core import thb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    thb_in_if.sink   din,
    thb_out_if.source dout,
    thb_cfg_if.sink  cfg
);

    // register file, reset to the power-on defaults
    logic [COUNT_W-1:0] dot_limit_reg;
    logic [DENS_W-1:0]  darkness_reg;
    logic [TIME_W-1:0]  base_heat_us_reg;
    logic [TIME_W-1:0]  cool_us_reg;
    logic [TIME_W-1:0]  step_wait_us_reg;

    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    cmd_t               q_cmd;
    cmd_t               q_head;
    store_wr_t          wr;
    bank_rel_t          rel;
    logic [BANK_W-1:0]  rd_bank;
    logic [SEG_W-1:0]   rd_seg;
    logic [DOTS_W-1:0]  rd_dots;

    // writes are always taken; only legal while the core is idle
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_limit_reg    <= COUNT_W'(24);
            darkness_reg     <= DENS_W'(80);
            base_heat_us_reg <= TIME_W'(2000);
            cool_us_reg      <= TIME_W'(200);
            step_wait_us_reg <= TIME_W'(800);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_DOT_LIMIT:    dot_limit_reg    <= cfg.data[COUNT_W-1:0];
                REG_DARKNESS:     darkness_reg     <= cfg.data[DENS_W-1:0];
                REG_BASE_HEAT_US: base_heat_us_reg <= cfg.data[TIME_W-1:0];
                REG_COOL_US:      cool_us_reg      <= cfg.data[TIME_W-1:0];
                REG_STEP_WAIT_US: step_wait_us_reg <= cfg.data[TIME_W-1:0];
                default:          dot_limit_reg    <= dot_limit_reg;
            endcase
        end
    end

    // front: dot counting, batch split, line end detection
    thb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din),
        .dot_limit (dot_limit_reg),
        .rel       (rel),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd),
        .wr        (wr)
    );

    // batches waiting for the back
    thb_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    // two banks: front fills one while back reads the other
    thb_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rel     (rel),
        .rd_bank (rd_bank),
        .rd_seg  (rd_seg),
        .rd_dots (rd_dots)
    );

    // back: segment words, motor steps, coils off
    thb_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .dout         (dout),
        .darkness     (darkness_reg),
        .base_heat_us (base_heat_us_reg),
        .cool_us      (cool_us_reg),
        .step_wait_us (step_wait_us_reg),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .rel          (rel),
        .rd_bank      (rd_bank),
        .rd_seg       (rd_seg),
        .rd_dots      (rd_dots)
    );

endmodule
